### design/i2ctrf_pkg.sv
// shared constants and types for the i2c target register file
package i2ctrf_pkg;

  localparam int DEFAULT_STORE_DEPTH = 16;
  localparam int BYTE_W = 8;

  // store access request from the control unit for one word
  typedef struct packed {
    logic wr;
    logic rd;
  } mem_req_t;

endpackage

### design/i2ctrf_ram.sv
// generic single write port, single registered read port ram
module i2ctrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### design/i2ctrf_ctrl.sv
// bus phase tracking, register pointer, offset and store entry valid bits
module i2ctrf_ctrl
  import i2ctrf_pkg::*;
#(
  parameter int STORE_DEPTH = DEFAULT_STORE_DEPTH,
  localparam int IDX_W = $clog2(STORE_DEPTH)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic              stop_seen,
  input  logic              start_seen,
  input  logic              byte_full,
  input  logic              read_not_write,
  input  logic [BYTE_W-1:0] rx_byte,
  output mem_req_t          mem_req,
  output logic [IDX_W-1:0]  addr,
  output logic              entry_valid
);

  typedef enum logic [2:0] {
    STOPPED     = 3'd0,
    STARTED     = 3'd1,
    REG_ADDRESS = 3'd2,
    WRITE       = 3'd3,
    READ        = 3'd4
  } phase_t;

  localparam logic [IDX_W:0]  LAST_IDX = (IDX_W+1)'(STORE_DEPTH - 1);
  localparam logic [BYTE_W:0] LAST_RX  = (BYTE_W+1)'(STORE_DEPTH - 1);

  phase_t                 phase, phase_next;
  logic [IDX_W-1:0]       reg_pointer, reg_pointer_next;
  logic [IDX_W-1:0]       offset, offset_next;
  logic [STORE_DEPTH-1:0] written;
  logic [IDX_W:0]         sum;
  logic [IDX_W-1:0]       cur_idx;
  logic                   can_advance;

  assign sum         = {1'b0, reg_pointer} + {1'b0, offset};
  assign can_advance = sum < LAST_IDX;
  assign cur_idx     = (sum > LAST_IDX) ? LAST_IDX[IDX_W-1:0] : sum[IDX_W-1:0];
  assign addr        = cur_idx;
  assign entry_valid = written[cur_idx];

  always_comb begin
    phase_next       = phase;
    reg_pointer_next = reg_pointer;
    offset_next      = offset;
    mem_req          = '0;
    if (accept) begin
      if (stop_seen) begin
        phase_next  = STOPPED;
        offset_next = '0;
      end else if (start_seen && !byte_full) begin
        phase_next  = STARTED;
        offset_next = '0;
      end else begin
        case (phase)
          STARTED: begin
            if (byte_full) begin
              if (!read_not_write) begin
                phase_next = REG_ADDRESS;
              end else begin
                phase_next = READ;
                mem_req.rd = 1'b1;
                if (can_advance) offset_next = offset + 1'b1;
              end
            end
          end
          REG_ADDRESS: begin
            // pointer beyond the store wraps to the first entry
            reg_pointer_next = ({1'b0, rx_byte} > LAST_RX) ? '0 : rx_byte[IDX_W-1:0];
            phase_next       = WRITE;
          end
          WRITE: begin
            mem_req.wr = 1'b1;
            if (can_advance) offset_next = offset + 1'b1;
          end
          READ: begin
            mem_req.rd = 1'b1;
            if (can_advance) offset_next = offset + 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= STOPPED;
      reg_pointer <= '0;
      offset      <= '0;
      written     <= '0;
    end else begin
      phase       <= phase_next;
      reg_pointer <= reg_pointer_next;
      offset      <= offset_next;
      if (mem_req.wr) begin
        written[cur_idx] <= 1'b1;
      end
    end
  end

endmodule

### design/i2c_target_register_file_unit.sv
// Register file behind an I2C target port. Each input word is one bus event
// (stop, start, byte received, direction bit, received byte). An event is
// taken in the cycle it is offered whenever the output register is empty or
// being emptied, so one event per clock is sustained. A read event returns
// its store byte in the cycle after acceptance, through the registered read
// port of the store ram. Write events and reads of entries never written
// since reset behave as the store held zeros after reset.
module i2c_target_register_file_unit
  import i2ctrf_pkg::*;
#(
  parameter int STORE_DEPTH = DEFAULT_STORE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              stop_seen,
  input  logic              start_seen,
  input  logic              byte_full,
  input  logic              read_not_write,
  input  logic [BYTE_W-1:0] rx_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] tx_byte
);

  localparam int IDX_W = $clog2(STORE_DEPTH);

  mem_req_t          mem_req;
  logic [IDX_W-1:0]  addr;
  logic              entry_valid;
  logic              entry_valid_q;
  logic [BYTE_W-1:0] rd_data;
  logic              accept;

  assign in_ready = !rst && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  i2ctrf_ctrl #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .stop_seen      (stop_seen),
    .start_seen     (start_seen),
    .byte_full      (byte_full),
    .read_not_write (read_not_write),
    .rx_byte        (rx_byte),
    .mem_req        (mem_req),
    .addr           (addr),
    .entry_valid    (entry_valid)
  );

  i2ctrf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_req.wr),
    .wr_addr (addr),
    .wr_data (rx_byte),
    .rd_en   (mem_req.rd),
    .rd_addr (addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (mem_req.rd) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // entry valid flag follows the ram read register
  always_ff @(posedge clk) begin
    if (mem_req.rd) begin
      entry_valid_q <= entry_valid;
    end
  end

  assign tx_byte = entry_valid_q ? rd_data : '0;

endmodule
